/* design/asd_pkg.sv */
// Shared types and constants for the audio spike detector.
`default_nettype none
package asd_pkg;

  localparam int SampleBits  = 12;
  localparam int ElapsedBits = 8;
  localparam int TimerBits   = 16;
  localparam int SumBits     = 19;
  localparam int CountBits   = 7;
  localparam int FracBits    = 10;
  localparam int CfgIdxBits  = 2;
  localparam int CfgDataBits = 16;

  localparam int InDataBits  = ((SampleBits + ElapsedBits + 7) / 8) * 8;
  localparam int OutDataBits = ((SampleBits + 7) / 8) * 8;

  localparam int ProdBits    = SampleBits + FracBits;
  localparam int ThrBits     = ProdBits - 8 + 1;

  localparam int QDepth      = 2;
  localparam int QPtrBits    = $clog2(QDepth);
  localparam int QCntBits    = $clog2(QDepth + 1);

  localparam int DivSteps    = SumBits;
  localparam int DivCntBits  = $clog2(DivSteps);

  localparam logic [SampleBits-1:0]  AvgReset      = SampleBits'(2048);
  localparam logic [TimerBits-1:0]   HoldoffReset  = TimerBits'(100);
  localparam logic [FracBits-1:0]    FracReset     = FracBits'(77);
  localparam logic [TimerBits-1:0]   LogPerReset   = TimerBits'(50);
  localparam logic [CountBits-1:0]   PerAvgReset   = CountBits'(20);

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_HOLDOFF  = 2'd0,
    CFG_FRACTION = 2'd1,
    CFG_LOG_PER  = 2'd2,
    CFG_PER_AVG  = 2'd3
  } cfg_idx_e;

  // One queued request from the front to the back part.
  typedef struct packed {
    logic                 spike;
    logic                 div;
    logic [SumBits-1:0]   sum;
    logic [CountBits-1:0] divisor;
  } job_t;

  // Average level published by the back part.
  typedef struct packed {
    logic                  upd;
    logic [SampleBits-1:0] level;
  } avg_t;

  // Front status seen by the top level.
  typedef struct packed {
    logic push;
    logic pending;
  } front_stat_t;

endpackage
`default_nettype wire

/* design/asd_queue.sv */
// Two-entry request queue between the front and back parts.
`default_nettype none
module asd_queue
  import asd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  job_t      job_i,
  input  wire logic pop_i,
  output job_t      job_o,
  output logic      full_o,
  output logic      empty_o
);

  job_t                mem_q [QDepth];
  logic [QPtrBits-1:0] wr_q, wr_d;
  logic [QPtrBits-1:0] rd_q, rd_d;
  logic [QCntBits-1:0] cnt_q, cnt_d;

  logic do_push, do_pop;

  assign full_o  = (cnt_q == QCntBits'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? wr_q + QPtrBits'(1) : wr_q;
    rd_d  = do_pop ? rd_q + QPtrBits'(1) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCntBits'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCntBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

endmodule
`default_nettype wire

/* design/asd_front.sv */
// Front part: takes samples, runs timers, spike test and peak/period bookkeeping.
`default_nettype none
module asd_front
  import asd_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  wire logic [CfgDataBits-1:0] cfg_data_i,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [SampleBits-1:0]  sample_i,
  input  wire logic [ElapsedBits-1:0] elapsed_i,
  input  avg_t                        avg_i,
  input  wire logic                   q_full_i,
  output logic                        push_o,
  output job_t                        job_o,
  output front_stat_t                 stat_o
);

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_EVAL} state_e;

  state_e state_q;

  logic [TimerBits-1:0]   holdoff_ms_q;
  logic [FracBits-1:0]    frac_q;
  logic [TimerBits-1:0]   log_per_q;
  logic [CountBits-1:0]   per_avg_q;

  logic [SampleBits-1:0]  smp_q;
  logic [ElapsedBits-1:0] dt_q;
  logic [ProdBits-1:0]    prod_q;

  logic [SampleBits-1:0]  peak_q, peak_d;
  logic [SumBits-1:0]     sum_q, sum_d;
  logic [CountBits-1:0]   cnt_q, cnt_d;
  logic [TimerBits-1:0]   ptimer_q, ptimer_d;
  logic [TimerBits-1:0]   htimer_q, htimer_d;
  logic                   pending_q;

  logic [TimerBits:0]     h_add, p_add;
  logic [TimerBits-1:0]   h_sat, p_sat;
  logic [ThrBits-1:0]     thr;
  logic                   spike;
  logic [SampleBits-1:0]  peak_new;
  logic [SumBits:0]       sum_add;
  logic [SumBits-1:0]     sum_sat;
  logic [CountBits-1:0]   cnt_inc;
  logic                   per_end, div_now;
  logic                   push;

  assign in_ready_o = (state_q == F_IDLE) && !pending_q;
  assign push       = (state_q == F_EVAL) && !q_full_i;

  always_comb begin
    h_add    = {1'b0, htimer_q} + (TimerBits + 1)'(dt_q);
    p_add    = {1'b0, ptimer_q} + (TimerBits + 1)'(dt_q);
    h_sat    = h_add[TimerBits] ? '1 : h_add[TimerBits-1:0];
    p_sat    = p_add[TimerBits] ? '1 : p_add[TimerBits-1:0];
    thr      = ThrBits'(avg_i.level) + ThrBits'(prod_q[ProdBits-1:8]);
    spike    = (h_sat > holdoff_ms_q) && (ThrBits'(smp_q) > thr);
    peak_new = (smp_q > peak_q) ? smp_q : peak_q;
    sum_add  = {1'b0, sum_q} + (SumBits + 1)'(peak_new);
    sum_sat  = sum_add[SumBits] ? '1 : sum_add[SumBits-1:0];
    cnt_inc  = cnt_q + CountBits'(1);
    per_end  = (p_sat >= log_per_q);
    div_now  = per_end && (cnt_inc >= per_avg_q);

    htimer_d = spike ? '0 : h_sat;
    ptimer_d = per_end ? '0 : p_sat;
    peak_d   = per_end ? '0 : peak_new;
    sum_d    = sum_q;
    cnt_d    = cnt_q;
    if (per_end) begin
      sum_d = div_now ? '0 : sum_sat;
      cnt_d = div_now ? '0 : cnt_inc;
    end

    job_o.spike   = spike;
    job_o.div     = div_now;
    job_o.sum     = sum_sat;
    job_o.divisor = (cnt_inc == '0) ? CountBits'(1) : cnt_inc;
  end

  assign push_o         = push;
  assign stat_o.push    = push;
  assign stat_o.pending = pending_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      holdoff_ms_q <= HoldoffReset;
      frac_q       <= FracReset;
      log_per_q    <= LogPerReset;
      per_avg_q    <= PerAvgReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_HOLDOFF:  holdoff_ms_q <= cfg_data_i[TimerBits-1:0];
        CFG_FRACTION: frac_q       <= cfg_data_i[FracBits-1:0];
        CFG_LOG_PER:  log_per_q    <= cfg_data_i[TimerBits-1:0];
        CFG_PER_AVG:  per_avg_q    <= cfg_data_i[CountBits-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= F_IDLE;
      peak_q    <= '0;
      sum_q     <= '0;
      cnt_q     <= '0;
      ptimer_q  <= '0;
      htimer_q  <= '0;
      pending_q <= 1'b0;
    end else begin
      // Hold new samples off from an average request until the back part publishes it.
      if (push && div_now) begin
        pending_q <= 1'b1;
      end else if (avg_i.upd) begin
        pending_q <= 1'b0;
      end
      unique case (state_q)
        F_IDLE: begin
          if (in_valid_i && in_ready_o) begin
            state_q <= F_MUL;
          end
        end
        F_MUL: begin
          state_q <= F_EVAL;
        end
        F_EVAL: begin
          if (push) begin
            state_q  <= F_IDLE;
            peak_q   <= peak_d;
            sum_q    <= sum_d;
            cnt_q    <= cnt_d;
            ptimer_q <= ptimer_d;
            htimer_q <= htimer_d;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      smp_q <= sample_i;
      dt_q  <= elapsed_i;
    end
    if (state_q == F_MUL) begin
      prod_q <= avg_i.level * frac_q;
    end
  end

endmodule
`default_nettype wire

/* design/asd_back.sv */
// Back part: divides the peak sum for a new average and drives the result register.
`default_nettype none
module asd_back
  import asd_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    q_empty_i,
  input  job_t                         job_i,
  output logic                         pop_o,
  output avg_t                         avg_o,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic                         out_spike_o,
  output logic [SampleBits-1:0]        out_avg_o
);

  typedef enum logic [1:0] {B_IDLE, B_DIV, B_OUT} state_e;

  state_e                 state_q;
  logic [SampleBits-1:0]  avg_q;
  logic                   upd_q;
  logic                   spike_q;
  logic [SumBits-1:0]     quo_q;
  logic [CountBits-1:0]   rem_q;
  logic [CountBits-1:0]   dvs_q;
  logic [DivCntBits-1:0]  step_q;
  logic                   out_valid_q;
  logic                   out_spike_q;
  logic [SampleBits-1:0]  out_avg_q;

  logic [CountBits:0]     trial;
  logic                   fits;
  logic [CountBits:0]     trial_sub;
  logic                   out_free;

  assign pop_o    = (state_q == B_IDLE) && !q_empty_i;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    trial     = {rem_q, quo_q[SumBits-1]};
    fits      = (trial >= {1'b0, dvs_q});
    trial_sub = trial - {1'b0, dvs_q};
  end

  assign avg_o.upd   = upd_q;
  assign avg_o.level = avg_q;
  assign out_valid_o = out_valid_q;
  assign out_spike_o = out_spike_q;
  assign out_avg_o   = out_avg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      avg_q       <= AvgReset;
      upd_q       <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      upd_q <= (state_q == B_DIV) && (step_q == '0);
      if (state_q == B_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        B_IDLE: begin
          if (pop_o) begin
            step_q  <= DivCntBits'(DivSteps - 1);
            state_q <= job_i.div ? B_DIV : B_OUT;
          end
        end
        B_DIV: begin
          if (step_q == '0) begin
            // Keep only the low sample bits of the quotient.
            avg_q   <= {quo_q[SampleBits-2:0], fits};
            state_q <= B_OUT;
          end else begin
            step_q <= step_q - DivCntBits'(1);
          end
        end
        B_OUT: begin
          if (out_free) begin
            state_q <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      spike_q <= job_i.spike;
      quo_q   <= job_i.sum;
      dvs_q   <= job_i.divisor;
      rem_q   <= '0;
    end else if (state_q == B_DIV) begin
      // One restoring step: shift in the next dividend bit, subtract when it fits.
      rem_q <= fits ? trial_sub[CountBits-1:0] : trial[CountBits-1:0];
      quo_q <= {quo_q[SumBits-2:0], fits};
    end
    if (state_q == B_OUT && out_free) begin
      out_spike_q <= spike_q;
      out_avg_q   <= avg_q;
    end
  end

endmodule
`default_nettype wire

/* design/audio_spike_detector.sv */
// Audio spike detector: one result per sample, spike flag and running average level.
// Flow: a new sample is taken only after the previous one has been pushed to the queue, which
//   stalls while the queue is full; after an averaging period end the next sample waits until
//   the 19-step restoring divider in the back part has written the new average.
// Reset: asynchronous, active low; registers return to their defaults, the average to 2048,
//   timers, peak, sum and count to zero, the queue and result register to empty.
`default_nettype none
module audio_spike_detector
  import asd_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [CfgIdxBits-1:0]   cfg_idx_i,
  input  wire logic [CfgDataBits-1:0]  cfg_data_i,
  input  wire logic                    s_axis_tvalid,
  output logic                         s_axis_tready,
  // [11:0] sample, [19:12] elapsed_ms, upper bits zero
  input  wire logic [InDataBits-1:0]   s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  wire logic                    m_axis_tready,
  // [11:0] average_level, upper bits zero
  output logic [OutDataBits-1:0]       m_axis_tdata,
  // [0] spike
  output logic                         m_axis_tuser
);

  job_t                   push_job, head_job;
  logic                   push, pop, q_full, q_empty;
  avg_t                   avg;
  front_stat_t            fstat;
  logic [SampleBits-1:0]  out_avg;

  asd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sample_i   (s_axis_tdata[SampleBits-1:0]),
    .elapsed_i  (s_axis_tdata[SampleBits+ElapsedBits-1:SampleBits]),
    .avg_i      (avg),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (push_job),
    .stat_o     (fstat)
  );

  asd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .job_o   (head_job),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  asd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .job_i       (head_job),
    .pop_o       (pop),
    .avg_o       (avg),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_spike_o (m_axis_tuser),
    .out_avg_o   (out_avg)
  );

  assign m_axis_tdata = OutDataBits'(out_avg);

  // A request never reaches a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) fstat.push |-> !q_full)
    else $error("request pushed into full queue");

  // No sample is taken while a new average is still being computed.
  assert property (@(posedge clk_i) disable iff (!rst_ni) s_axis_tready |-> !fstat.pending)
    else $error("sample accepted during average update");

  // The average changes only when the front part waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni) avg.upd |-> fstat.pending)
    else $error("average update without pending request");

  // A pushed average request holds off the next sample.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (fstat.push && push_job.div) |=> !s_axis_tready)
    else $error("sample accepted right after average request");

endmodule
`default_nettype wire

/* dv/tb_top.sv */
// Testbench for the audio spike detector: table and random samples against a predictor.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import asd_pkg::*;

  localparam int CycleLimit = 600000;
  localparam int StallCycles = 300;
  localparam logic [SumBits-1:0] SumMax = '1;

  typedef struct packed {
    logic                  spike;
    logic [SampleBits-1:0] level;
  } detect_rep_t;

  typedef struct packed {
    logic [SampleBits-1:0]  smp;
    logic [ElapsedBits-1:0] dt;
    logic                   typed;
    logic                   spike;
    logic [SampleBits-1:0]  level;
  } sample_row_t;

  typedef struct packed {
    logic [TimerBits-1:0] holdoff;
    logic [FracBits-1:0]  frac;
    logic [TimerBits-1:0] log_per;
    logic [CountBits-1:0] per_avg;
    int                   n;
    int                   dt_lo;
    int                   dt_hi;
  } reg_setting_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  cfg_idx_e               cfg_idx_i = CFG_HOLDOFF;
  logic [CfgDataBits-1:0] cfg_data_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [InDataBits-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OutDataBits-1:0] m_axis_tdata;
  logic                   m_axis_tuser;

  audio_spike_detector u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // Predictor copy of the detector state and registers.
  logic [SampleBits-1:0] trk_peak;
  logic [SumBits-1:0]    trk_sum;
  logic [CountBits-1:0]  trk_count;
  logic [SampleBits-1:0] trk_avg;
  logic [TimerBits-1:0]  trk_per_tmr;
  logic [TimerBits-1:0]  trk_hold_tmr;
  logic [TimerBits-1:0]  reg_holdoff = HoldoffReset;
  logic [FracBits-1:0]   reg_frac = FracReset;
  logic [TimerBits-1:0]  reg_log_per = LogPerReset;
  logic [CountBits-1:0]  reg_per_avg = PerAvgReset;

  detect_rep_t reports_q[$];
  int errors = 0;
  int n_samples = 0;
  int n_settings = 1;
  int n_spikes = 0;
  int n_avg_updates = 0;
  int cycles = 0;
  int stall_req = 0;
  int stall_seen = 0;
  int stall_left = 0;
  int pat_left = 0;
  int pat_mode = 0;

  sample_row_t sample_rows [0:13] = '{
    '{12'd0,    8'd0,   1'b1, 1'b0, 12'd2048},
    '{12'd4095, 8'd0,   1'b1, 1'b0, 12'd2048},
    '{12'd4095, 8'd255, 1'b1, 1'b1, 12'd2048},
    '{12'd2664, 8'd200, 1'b0, 1'b0, 12'd0},   // equal to threshold
    '{12'd2665, 8'd0,   1'b0, 1'b0, 12'd0},   // one above threshold
    '{12'd4095, 8'd100, 1'b0, 1'b0, 12'd0},   // hold-off timer equal to limit
    '{12'd4095, 8'd1,   1'b0, 1'b0, 12'd0},
    '{12'hAAA,  8'h55,  1'b0, 1'b0, 12'd0},
    '{12'h555,  8'hAA,  1'b0, 1'b0, 12'd0},
    '{12'd0,    8'd49,  1'b0, 1'b0, 12'd0},
    '{12'd0,    8'd1,   1'b0, 1'b0, 12'd0},
    '{12'hFFF,  8'd255, 1'b0, 1'b0, 12'd0},
    '{12'd1,    8'd254, 1'b0, 1'b0, 12'd0},
    '{12'd2048, 8'd50,  1'b0, 1'b0, 12'd0}
  };

  // Low extremes, high extremes with saturating timers, zero period and count, huge fraction.
  reg_setting_t fixed_settings [0:3] = '{
    '{16'd0,     10'd0,    16'd1,     7'd1,   100, 0,   255},
    '{16'd65535, 10'd1023, 16'd65535, 7'd127, 300, 200, 255},
    '{16'd20,    10'd128,  16'd0,     7'd0,   150, 0,   40},
    '{16'd10,    10'd1023, 16'd50,    7'd20,  150, 0,   40}
  };

  function automatic logic [TimerBits-1:0] timer_add(logic [TimerBits-1:0] t,
                                                      logic [ElapsedBits-1:0] d);
    logic [TimerBits:0] s;
    s = {1'b0, t} + (TimerBits + 1)'(d);
    return s[TimerBits] ? '1 : s[TimerBits-1:0];
  endfunction

  task automatic track_sample(input logic [SampleBits-1:0] smp,
                              input logic [ElapsedBits-1:0] dt, output logic spk);
    logic [ProdBits-1:0]  prod;
    logic [ThrBits-1:0]   thr;
    logic [SumBits:0]     sum_n;
    logic [CountBits-1:0] div;
    logic [SumBits-1:0]   quot;
    trk_hold_tmr = timer_add(trk_hold_tmr, dt);
    trk_per_tmr  = timer_add(trk_per_tmr, dt);
    prod = ProdBits'(trk_avg) * ProdBits'(reg_frac);
    thr = ThrBits'(trk_avg) + ThrBits'(prod[ProdBits-1:8]);
    spk = (trk_hold_tmr > reg_holdoff) && (ThrBits'(smp) > thr);
    if (spk) trk_hold_tmr = '0;
    if (smp > trk_peak) trk_peak = smp;
    if (trk_per_tmr >= reg_log_per) begin
      sum_n = trk_sum + trk_peak;
      trk_sum = (sum_n > SumMax) ? SumMax : sum_n[SumBits-1:0];
      trk_peak = '0;
      trk_count = trk_count + 1'b1;
      trk_per_tmr = '0;
      if (trk_count >= reg_per_avg) begin
        div = (trk_count == '0) ? CountBits'(1) : trk_count;
        quot = trk_sum / div;
        trk_avg = quot[SampleBits-1:0];
        trk_sum = '0;
        trk_count = '0;
        n_avg_updates++;
      end
    end
  endtask

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 50) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic push_sample(input logic [SampleBits-1:0] smp, input logic [ElapsedBits-1:0] dt,
                             input logic typed, input logic t_spk,
                             input logic [SampleBits-1:0] t_lvl);
    detect_rep_t rep;
    logic spk;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InDataBits'({dt, smp});
    do @(posedge clk_i); while (!s_axis_tready);
    track_sample(smp, dt, spk);
    rep.spike = typed ? t_spk : spk;
    rep.level = typed ? t_lvl : trk_avg;
    reports_q.push_back(rep);
    n_samples++;
  endtask

  // Drop the request, let every result come back, then let the divider settle.
  task automatic wait_drain();
    int guard;
    guard = 0;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (reports_q.size() != 0 && guard < 50000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataBits-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_HOLDOFF:  reg_holdoff = val;
      CFG_FRACTION: reg_frac = val[FracBits-1:0];
      CFG_LOG_PER:  reg_log_per = val;
      CFG_PER_AVG:  reg_per_avg = val[CountBits-1:0];
      default: ;
    endcase
  endtask

  // Receiver: one long hold-off on request, otherwise a pattern of ready modes.
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (stall_seen != stall_req) begin
      stall_seen = stall_req;
      stall_left = StallCycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      if (pat_left == 0) begin
        pat_mode = $urandom_range(0, 2);
        pat_left = $urandom_range(20, 200);
      end else begin
        pat_left = pat_left - 1;
      end
      case (pat_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        default: m_axis_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin : check_reports
    detect_rep_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (m_axis_tuser) n_spikes++;
      if (reports_q.size() == 0) begin
        report_mismatch("result with no sample waiting");
      end else begin
        want = reports_q.pop_front();
        if (m_axis_tuser !== want.spike)
          report_mismatch($sformatf("spike got %0b want %0b", m_axis_tuser, want.spike));
        if (m_axis_tdata[SampleBits-1:0] !== want.level)
          report_mismatch($sformatf("average_level got %0d want %0d",
                                    m_axis_tdata[SampleBits-1:0], want.level));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, reports_q.size());
      $display("FAIL audio_spike_detector");
      $finish;
    end
  end

  initial begin
    int ph;
    int k;
    int r;
    int gap;
    int burst_left;
    int quiet_top;
    logic [SampleBits-1:0]  smp;
    logic [ElapsedBits-1:0] dt;
    reg_setting_t cur;

    burst_left = 0;
    trk_peak = '0;
    trk_sum = '0;
    trk_count = '0;
    trk_avg = AvgReset;
    trk_per_tmr = '0;
    trk_hold_tmr = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (k = 0; k < 14; k++)
      push_sample(sample_rows[k].smp, sample_rows[k].dt, sample_rows[k].typed,
                  sample_rows[k].spike, sample_rows[k].level);

    for (ph = 0; ph < 8; ph++) begin
      if (ph < 4) begin
        cur = fixed_settings[ph];
      end else begin
        cur.holdoff = TimerBits'($urandom_range(0, 300));
        cur.frac    = FracBits'($urandom_range(0, 400));
        cur.log_per = TimerBits'($urandom_range(1, 100));
        cur.per_avg = CountBits'($urandom_range(1, 8));
        cur.n       = 100;
        cur.dt_lo   = 0;
        cur.dt_hi   = 30;
      end
      wait_drain();
      write_reg(CFG_HOLDOFF, cur.holdoff);
      write_reg(CFG_FRACTION, CfgDataBits'(cur.frac));
      write_reg(CFG_LOG_PER, cur.log_per);
      write_reg(CFG_PER_AVG, CfgDataBits'(cur.per_avg));
      n_settings++;
      quiet_top = $urandom_range(200, 2000);

      for (k = 0; k < cur.n; k++) begin
        if (k == cur.n / 2) stall_req++;
        // Bursts of back-to-back requests separated by random gaps.
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          if (gap > 0) begin
            @(negedge clk_i);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk_i);
          end
        end else begin
          burst_left--;
        end
        // Mostly background level, some loud bursts, some raw noise.
        r = $urandom_range(0, 99);
        if (r < 70) smp = SampleBits'($urandom_range(0, quiet_top));
        else if (r < 90) smp = SampleBits'($urandom_range(2500, 4095));
        else smp = SampleBits'($urandom);
        r = $urandom_range(0, 19);
        if (r == 0) dt = '0;
        else if (r == 1) dt = '1;
        else dt = ElapsedBits'($urandom_range(cur.dt_lo, cur.dt_hi));
        push_sample(smp, dt, 1'b0, 1'b0, '0);
      end
    end

    wait_drain();
    if (reports_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", reports_q.size()));
    $display("Run: %0d samples under %0d register settings, %0d spikes, %0d average updates",
             n_samples, n_settings, n_spikes, n_avg_updates);
    $display("Included zero period and count, saturated timers, long output back-pressure");
    if (errors == 0) begin
      $display("PASS audio_spike_detector");
    end else begin
      $display("FAIL audio_spike_detector");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* files.f */
design/asd_pkg.sv
design/asd_queue.sv
design/asd_front.sv
design/asd_back.sv
design/audio_spike_detector.sv
dv/tb_top.sv
